### rtl/core/hmm_forward_probability_defines.svh
// ----------------------------------------------------------------------------
// hmm forward probability assertion macros
// concurrent assertion forms for the hmm_forward_probability module
// ----------------------------------------------------------------------------
`ifndef HMM_FORWARD_PROBABILITY_DEFINES_SVH
`define HMM_FORWARD_PROBABILITY_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define HFP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hfp assertion failed");

// next-cycle implication
`define HFP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hfp assertion failed");

`endif

### rtl/core/hfp_pkg.sv
// ----------------------------------------------------------------------------
// hfp package
// shared types and constants of the hmm forward probability block
// ----------------------------------------------------------------------------
package hfp_pkg;

    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 16;

    localparam int VAL_W   = 17;
    localparam int ALPHA_W = 32;
    localparam int ACC_W   = 56;
    localparam int SUM_W   = 33;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;

    localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0]
    {
        KIND_TRANS = 2'd0,
        KIND_EMIT  = 2'd1,
        KIND_INIT  = 2'd2,
        KIND_OBS   = 2'd3
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MAC,
        ST_EMUL,
        ST_SHIFT,
        ST_SUM,
        ST_OUT
    } state_t;

    // control from sequencer to each cell
    typedef struct packed
    {
        logic shift;     // rotate the alpha ring by one cell
        logic load_new;  // latch new alpha into the ring
    } cell_ctl_t;

    function automatic logic [ALPHA_W-1:0] sat32(input logic [63:0] v);
        logic [ALPHA_W-1:0] r;
        r = (v[63:ALPHA_W] != '0) ? '1 : v[ALPHA_W-1:0];
        return r;
    endfunction

endpackage

### rtl/core/hfp_cell.sv
// ----------------------------------------------------------------------------
// hfp cell
// one alpha slot of the ring; alpha values circulate through the chain
// ----------------------------------------------------------------------------
module hfp_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  hfp_pkg::cell_ctl_t           ctl,
    input  logic [hfp_pkg::ALPHA_W-1:0]  alpha_in,
    input  logic [hfp_pkg::ALPHA_W-1:0]  new_alpha,
    output logic [hfp_pkg::ALPHA_W-1:0]  alpha_out
);
    import hfp_pkg::*;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] alpha_next;

    always_comb
    begin
        alpha_next = alpha_reg;
        if (ctl.load_new)
            alpha_next = new_alpha;
        else if (ctl.shift)
            alpha_next = alpha_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= '0;
        else
            alpha_reg <= alpha_next;
    end

    assign alpha_out = alpha_reg;
endmodule

### rtl/core/hmm_forward_probability.sv
// ----------------------------------------------------------------------------
// hmm forward probability
// forward recursion over a ring of alpha cells with one shared mac
// ----------------------------------------------------------------------------
// load items are taken while idle; after an observation is accepted the
// block is busy and works through, for n states in use and per target state,
// a read and a mac per source state, shifts to finish the ring turn and one
// emission multiply (for the first of a sequence only a read and the emission
// multiply); a last observation adds a sum pass over the ring and an output
// step, and no item is taken until the result is accepted
// reset (rst_n low, asynchronous) clears control, rearms for a first
// observation and sets states_in_use to 16; tables are undefined until loaded
module hmm_forward_probability
#(
    parameter int MAX_STATES  = hfp_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = hfp_pkg::MAX_SYMBOLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config register
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[3:0] column[7:4] value[24:8] symbol[28:25]
    input  logic [1:0]  s_tuser,   // kind
    input  logic        s_tlast,   // last
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // sequence_probability[32:0]
);
    import hfp_pkg::*;
    `include "hmm_forward_probability_defines.svh"

    localparam int SW  = $clog2(MAX_STATES);
    localparam int YW  = $clog2(MAX_SYMBOLS);
    localparam int CW  = $clog2(MAX_STATES + 1);
    localparam int TW  = $clog2(MAX_STATES * MAX_STATES);
    localparam int EW  = $clog2(MAX_STATES * MAX_SYMBOLS);

    // tables
    logic [VAL_W-1:0] trans_mem [MAX_STATES*MAX_STATES];
    logic [VAL_W-1:0] emit_mem  [MAX_STATES*MAX_SYMBOLS];
    logic [VAL_W-1:0] init_mem  [MAX_STATES];
    logic [VAL_W-1:0] trans_rd_reg, emit_rd_reg, init_rd_reg;

    // input fields
    logic [3:0]       f_row, f_col, f_sym;
    logic [VAL_W-1:0] f_val, val_sat;
    kind_t            f_kind;
    assign f_row  = s_tdata[3:0];
    assign f_col  = s_tdata[7:4];
    assign f_val  = s_tdata[24:8];
    assign f_sym  = s_tdata[28:25];
    assign f_kind = kind_t'(s_tuser);
    assign val_sat = (f_val > ONE_Q16) ? ONE_Q16 : f_val;

    logic [CFG_W-1:0] siu_reg;
    logic [CW-1:0]    n_use;
    always_comb
    begin
        if (siu_reg == '0)
            n_use = CW'(1);
        else if (32'(siu_reg) > MAX_STATES)
            n_use = CW'(MAX_STATES);
        else
            n_use = CW'(siu_reg);
    end

    state_t state_reg, state_next;
    logic first_reg, first_next;
    logic last_reg, last_next;
    logic sym_ok_reg, sym_ok_next;
    logic [YW-1:0] sym_reg, sym_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] tot_reg, tot_next;
    logic [ALPHA_W-1:0] newa [MAX_STATES];
    logic [ALPHA_W-1:0] newa_v;
    logic newa_we;
    logic m_valid_reg, m_valid_next;
    logic [SUM_W-1:0] m_data_reg, m_data_next;
    logic rd_phase_reg, rd_phase_next;

    // alpha ring
    cell_ctl_t ctl;
    logic [ALPHA_W-1:0] ring [MAX_STATES];
    genvar g;
    generate
        for (g = 0; g < MAX_STATES; g++)
        begin : g_cell
            hfp_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .alpha_in  (ring[(g + 1) % MAX_STATES]),
                .new_alpha (newa[g]),
                .alpha_out (ring[g])
            );
        end
    endgenerate
    logic [ALPHA_W-1:0] head;
    assign head = ring[0];

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire = s_tvalid && s_tready;

    // table writes and reads (registered)
    logic [SW-1:0] rd_i, rd_j;
    assign rd_i = i_reg[SW-1:0];
    assign rd_j = j_reg[SW-1:0];
    always_ff @(posedge clk)
    begin
        if (s_fire && f_kind == KIND_TRANS && 32'(f_row) < MAX_STATES
            && 32'(f_col) < MAX_STATES)
            trans_mem[TW'(32'(f_row) * MAX_STATES + 32'(f_col))] <= val_sat;
        if (s_fire && f_kind == KIND_EMIT && 32'(f_row) < MAX_STATES
            && 32'(f_col) < MAX_SYMBOLS)
            emit_mem[EW'(32'(f_row) * MAX_SYMBOLS + 32'(f_col))] <= val_sat;
        if (s_fire && f_kind == KIND_INIT && 32'(f_col) < MAX_STATES)
            init_mem[SW'(f_col)] <= val_sat;
        trans_rd_reg <= trans_mem[TW'(32'(rd_j) * MAX_STATES + 32'(rd_i))];
        emit_rd_reg  <= emit_mem[EW'(32'(rd_i) * MAX_SYMBOLS + 32'(sym_reg))];
        init_rd_reg  <= init_mem[rd_i];
    end

    // mac products
    logic [48:0] prod_ta;
    logic [63:0] prod_e;
    logic [ALPHA_W-1:0] acc_sat;
    logic [VAL_W-1:0] e_val;
    logic [SUM_W-1:0] tot_sum;
    assign prod_ta = 49'(trans_rd_reg) * 49'(head);
    assign acc_sat = sat32(64'(acc_reg >> 16));
    assign e_val = sym_ok_reg ? emit_rd_reg : '0;
    assign prod_e = first_reg ? 64'(e_val) * 64'(init_rd_reg)
                              : (64'(acc_sat) * 64'(e_val)) >> 16;
    // running total stays at or below 1.0, so one more alpha fits in 33 bits
    assign tot_sum = tot_reg + SUM_W'(head);

    // sequencer: for each target i, walk the ring with a read cycle before each
    // mac, finish the ring turn, then emission multiply (first observation: no walk)
    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        last_next = last_reg;
        sym_next = sym_reg;
        sym_ok_next = sym_ok_reg;
        i_next = i_reg;
        j_next = j_reg;
        acc_next = acc_reg;
        tot_next = tot_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        rd_phase_next = rd_phase_reg;
        ctl = '0;
        newa_we = 1'b0;
        newa_v = '0;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && f_kind == KIND_OBS)
                begin
                    last_next = s_tlast;
                    sym_next = YW'(f_sym);
                    sym_ok_next = 32'(f_sym) < MAX_SYMBOLS;
                    i_next = '0;
                    j_next = '0;
                    acc_next = '0;
                    rd_phase_next = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                // rd_phase: table data for (j,i) arrives next cycle
                if (rd_phase_reg || first_reg)
                begin
                    rd_phase_next = 1'b0;
                    if (first_reg)
                        state_next = ST_EMUL;
                end
                else
                begin
                    acc_next = acc_reg + ACC_W'(prod_ta);
                    ctl.shift = 1'b1;
                    if (j_reg == n_use - CW'(1))
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        j_next = j_reg + CW'(1);
                        rd_phase_next = 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                // realign ring after n rotations when n < MAX_STATES
                if (j_reg == CW'(MAX_STATES - 1))
                    state_next = ST_EMUL;
                else
                begin
                    ctl.shift = 1'b1;
                    j_next = j_reg + CW'(1);
                end
            end
            ST_EMUL:
            begin
                newa_we = 1'b1;
                newa_v = sat32(prod_e);
                acc_next = '0;
                j_next = '0;
                rd_phase_next = 1'b1;
                if (i_reg == n_use - CW'(1))
                begin
                    ctl.load_new = 1'b1;
                    first_next = 1'b0;
                    tot_next = '0;
                    state_next = last_reg ? ST_SUM : ST_IDLE;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = ST_MAC;
                end
            end
            ST_SUM:
            begin
                // saturate at 1.0 on every step
                tot_next = (tot_sum > {1'b1, 32'd0}) ? {1'b1, 32'd0} : tot_sum;
                ctl.shift = 1'b1;
                if (j_reg == CW'(MAX_STATES - 1))
                    state_next = ST_OUT;
                else
                    j_next = j_reg + CW'(1);
            end
            ST_OUT:
            begin
                m_valid_next = 1'b1;
                m_data_next = (tot_reg > {1'b1, 32'd0}) ? {1'b1, 32'd0} : tot_reg;
                first_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // new alpha holding row; unused states are zero
    logic [ALPHA_W-1:0] newa_reg [MAX_STATES];
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_STATES; k++)
        begin
            if (state_reg == ST_IDLE && s_fire && f_kind == KIND_OBS)
                newa_reg[k] <= '0;
            else if (newa_we && i_reg == CW'(k))
                newa_reg[k] <= newa_v;
        end
    end
    always_comb
    begin
        for (int k = 0; k < MAX_STATES; k++)
        begin
            newa[k] = newa_reg[k];
            if (newa_we && i_reg == CW'(k))
                newa[k] = newa_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            siu_reg <= CFG_W'(16);
            rd_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            m_valid_reg <= m_valid_next;
            rd_phase_reg <= rd_phase_next;
            if (cfg_we)
                siu_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        sym_reg <= sym_next;
        sym_ok_reg <= sym_ok_next;
        i_reg <= i_next;
        j_reg <= j_next;
        acc_reg <= acc_next;
        tot_reg <= tot_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    `HFP_ASSERT_IMP(a_busy_no_ready, clk, rst_n, state_reg != ST_IDLE, !s_tready)
    `HFP_ASSERT_IMP(a_out_bound, clk, rst_n, m_valid_reg, m_data_reg <= {1'b1, 32'd0})
    `HFP_ASSERT_NXT(a_out_rearm, clk, rst_n, state_reg == ST_OUT, first_reg && m_valid_reg)
endmodule
